### src/arqswt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARQ send window tracker package
// Shared widths, reset values and codes for the window tracker.
// ----------------------------------------------------------------------------
package arqswt_pkg;

	localparam int SLOTS_DEF     = 10;
	localparam int MAX_CHUNK_DEF = 1024;

	localparam int TYPE_W    = 2;
	localparam int CHUNK_W   = 11;
	localparam int SEQ_W     = 32;
	localparam int WIN_W     = 16;
	localparam int ELAPSED_W = 10;
	localparam int TIMEOUT_W = 16;
	localparam int CLOCK_W   = 32;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;

	localparam logic [WIN_W-1:0]     RESET_WINDOW  = WIN_W'(8192);
	localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT = TIMEOUT_W'(500);
	localparam logic [SEQ_W-1:0]     RESET_SEQ     = SEQ_W'(1);

	typedef enum logic [TYPE_W-1:0] {
		REQ_SEND = 2'd0,
		REQ_ACK  = 2'd1,
		REQ_TICK = 2'd2
	} req_type_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SEND = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_RETX = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_WIN_FULL = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_NO_SLOT  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEND,
		S_SCAN,
		S_ACK_DONE,
		S_TICK_DONE
	} state_t;

endpackage
`default_nettype wire

### src/arqswt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARQ request channel
// One beat carries a send request, an acknowledgement or a time tick.
// ----------------------------------------------------------------------------
interface arqswt_req_if;
	import arqswt_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [TYPE_W-1:0]    req_type;
	logic [CHUNK_W-1:0]   chunk_len;
	logic [SEQ_W-1:0]     ack_number;
	logic [WIN_W-1:0]     adv_window;
	logic [ELAPSED_W-1:0] elapsed_ms;

	modport source (
		output valid, req_type, chunk_len, ack_number, adv_window, elapsed_ms,
		input  ready
	);

	modport sink (
		input  valid, req_type, chunk_len, ack_number, adv_window, elapsed_ms,
		output ready
	);
endinterface
`default_nettype wire

### src/arqswt_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARQ result channel
// One beat carries a send answer, an ack answer or a retransmit order.
// ----------------------------------------------------------------------------
interface arqswt_res_if #(
	parameter int LEN_W = 11,
	parameter int IDX_W = 4,
	parameter int BIF_W = 14,
	parameter int CNT_W = 4
);
	import arqswt_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   result_kind;
	logic [STATUS_W-1:0] status;
	logic [SEQ_W-1:0]    seq_number;
	logic [LEN_W-1:0]    length;
	logic [IDX_W-1:0]    slot_index;
	logic [BIF_W-1:0]    bytes_in_flight;
	logic [CNT_W-1:0]    freed_count;
	logic                last;

	modport source (
		output valid, result_kind, status, seq_number, length, slot_index,
		       bytes_in_flight, freed_count, last,
		input  ready
	);

	modport sink (
		input  valid, result_kind, status, seq_number, length, slot_index,
		       bytes_in_flight, freed_count, last,
		output ready
	);
endinterface
`default_nettype wire

### src/arqswt_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARQ slot table memory
// One write port and one registered read port; holds seq, length and stamp.
// ----------------------------------------------------------------------------
module arqswt_slot_ram #(
	parameter int DEPTH  = 10,
	parameter int IDX_W  = 4,
	parameter int DATA_W = 75
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### src/arqswt_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ARQ result register
// Holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module arqswt_out_reg #(
	parameter int LEN_W = 11,
	parameter int IDX_W = 4,
	parameter int BIF_W = 14,
	parameter int CNT_W = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  arqswt_pkg::kind_t             kind,
	input  arqswt_pkg::status_t           status,
	input  logic [arqswt_pkg::SEQ_W-1:0]  seq,
	input  logic [LEN_W-1:0]              len,
	input  logic [IDX_W-1:0]              slot,
	input  logic [BIF_W-1:0]              bif,
	input  logic [CNT_W-1:0]              freed,
	input  logic                          last,
	output logic                          free,
	arqswt_res_if.source                  res
);
	import arqswt_pkg::*;

	logic                valid_q;
	kind_t               kind_q;
	status_t             status_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]    slot_q;
	logic [BIF_W-1:0]    bif_q;
	logic [CNT_W-1:0]    freed_q;
	logic                last_q;

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q   <= kind;
			status_q <= status;
			seq_q    <= seq;
			len_q    <= len;
			slot_q   <= slot;
			bif_q    <= bif;
			freed_q  <= freed;
			last_q   <= last;
		end
	end

	assign res.valid           = valid_q;
	assign res.result_kind     = kind_q;
	assign res.status          = status_q;
	assign res.seq_number      = seq_q;
	assign res.length          = len_q;
	assign res.slot_index      = slot_q;
	assign res.bytes_in_flight = bif_q;
	assign res.freed_count     = freed_q;
	assign res.last            = last_q;
endmodule
`default_nettype wire

### src/arq_send_window_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Send: the result is pushed into the output register from S_SEND once that
// register is free. Ack and tick: the slot memory walk does one read per cycle
// unless a retransmit beat waits on the output; retransmit beats follow as found.
// One item at a time: req.ready is high only while the tracker is idle.
// Reset is asynchronous; it loads the reset window and clears clock, busy bits
// and counters at once; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// ARQ send window tracker
// Slot table in a synchronous memory, walked for acks and retransmit ticks.
// ----------------------------------------------------------------------------
module arq_send_window_tracker #(
	parameter int SLOTS     = arqswt_pkg::SLOTS_DEF,
	parameter int MAX_CHUNK = arqswt_pkg::MAX_CHUNK_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [arqswt_pkg::TIMEOUT_W-1:0]   cfg_wdata,
	arqswt_req_if.sink                         req,
	arqswt_res_if.source                       res
);
	import arqswt_pkg::*;

	localparam int LEN_W = $clog2(MAX_CHUNK + 1);
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int BIF_W = $clog2(SLOTS * MAX_CHUNK + 1);
	localparam int ENT_W = SEQ_W + LEN_W + CLOCK_W;

	state_t               state_q, state_d;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [SEQ_W-1:0]     next_seq_q;
	logic [WIN_W-1:0]     peer_q;
	logic [CLOCK_W-1:0]   clock_q;
	logic [BIF_W-1:0]     bif_q;
	logic [SLOTS-1:0]     busy_q;
	logic                 is_tick_q;
	logic [CNT_W-1:0]     rd_cnt_q;
	logic [CNT_W-1:0]     freed_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 pend_valid_q;
	logic [SEQ_W-1:0]     pend_seq_q;
	logic [LEN_W-1:0]     pend_len_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic [SEQ_W-1:0]     ack_q;
	logic [LEN_W-1:0]     len_q;

	logic                 accept;
	logic [LEN_W-1:0]     len_sat;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [ENT_W-1:0]     mem_wdata;
	logic                 mem_re;
	logic [ENT_W-1:0]     mem_rdata;
	logic [SEQ_W-1:0]     rd_seq;
	logic [LEN_W-1:0]     rd_len;
	logic [CLOCK_W-1:0]   rd_stamp;

	logic                 hit_busy;
	logic                 ack_free;
	logic                 due;
	logic                 advance;
	logic                 issue;
	logic                 scan_end;
	logic                 send_ok;
	logic                 send_go;
	status_t              send_status;
	logic [IDX_W-1:0]     free_idx;
	logic                 free_found;

	logic                 push;
	logic                 out_free;
	kind_t                o_kind;
	status_t              o_status;
	logic [SEQ_W-1:0]     o_seq;
	logic [LEN_W-1:0]     o_len;
	logic [IDX_W-1:0]     o_slot;
	logic [BIF_W-1:0]     o_bif;
	logic [CNT_W-1:0]     o_freed;
	logic                 o_last;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign len_sat   = (32'(req.chunk_len) > 32'(MAX_CHUNK)) ?
	                   LEN_W'(MAX_CHUNK) : LEN_W'(req.chunk_len);

	assign {rd_seq, rd_len, rd_stamp} = mem_rdata;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end
	assign free_found = !(&busy_q);

	always_comb begin
		if (32'(bif_q) >= 32'(peer_q)) begin
			send_status = ST_WIN_FULL;
		end else if (32'(bif_q) + 32'(len_q) > 32'(peer_q)) begin
			send_status = ST_OVERFLOW;
		end else if (!free_found) begin
			send_status = ST_NO_SLOT;
		end else begin
			send_status = ST_OK;
		end
	end
	assign send_ok = (send_status == ST_OK);

	assign hit_busy = valid_s1 && busy_q[idx_s1];
	assign ack_free = hit_busy &&
	                  ({1'b0, rd_seq} + (SEQ_W + 1)'(rd_len) <= {1'b0, ack_q});
	assign due      = hit_busy && ((clock_q - rd_stamp) >= CLOCK_W'(timeout_q));

	always_comb begin
		state_d   = state_q;
		advance   = 1'b0;
		issue     = 1'b0;
		scan_end  = 1'b0;
		send_go   = 1'b0;
		push      = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = free_idx;
		mem_wdata = {next_seq_q, len_q, clock_q};
		o_kind    = KIND_SEND;
		o_status  = ST_OK;
		o_seq     = '0;
		o_len     = '0;
		o_slot    = '0;
		o_bif     = bif_q;
		o_freed   = '0;
		o_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type_t'(req.req_type))
						REQ_SEND: state_d = S_SEND;
						REQ_ACK:  state_d = S_SCAN;
						REQ_TICK: state_d = S_SCAN;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_SEND: begin
				o_status = send_status;
				if (send_ok) begin
					o_seq  = next_seq_q;
					o_len  = len_q;
					o_slot = free_idx;
					o_bif  = bif_q + BIF_W'(len_q);
				end
				if (out_free) begin
					push    = 1'b1;
					send_go = 1'b1;
					mem_we  = send_ok;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				o_kind   = KIND_RETX;
				o_seq    = pend_seq_q;
				o_len    = pend_len_q;
				o_slot   = pend_idx_q;
				o_last   = 1'b0;
				advance  = !(is_tick_q && due && pend_valid_q && !out_free);
				issue    = advance && (rd_cnt_q != CNT_W'(SLOTS));
				scan_end = (rd_cnt_q == CNT_W'(SLOTS)) && !valid_s1;
				if (is_tick_q && due && pend_valid_q && out_free) begin
					push = 1'b1;
				end
				if (is_tick_q && due && advance) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1;
					mem_wdata = {rd_seq, rd_len, clock_q};
				end
				if (scan_end) begin
					state_d = is_tick_q ? S_TICK_DONE : S_ACK_DONE;
				end
			end
			S_ACK_DONE: begin
				o_kind  = KIND_ACK;
				o_freed = freed_q;
				if (out_free) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TICK_DONE: begin
				o_kind = KIND_RETX;
				o_seq  = pend_seq_q;
				o_len  = pend_len_q;
				o_slot = pend_idx_q;
				if (!pend_valid_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign mem_re = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= RESET_TIMEOUT;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q   <= RESET_SEQ;
			peer_q       <= RESET_WINDOW;
			clock_q      <= '0;
			bif_q        <= '0;
			busy_q       <= '0;
			is_tick_q    <= 1'b0;
			rd_cnt_q     <= '0;
			freed_q      <= '0;
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				rd_cnt_q     <= '0;
				valid_s1     <= 1'b0;
				freed_q      <= '0;
				pend_valid_q <= 1'b0;
				is_tick_q    <= (req_type_t'(req.req_type) == REQ_TICK);
				if (req_type_t'(req.req_type) == REQ_ACK) begin
					peer_q <= req.adv_window;
				end
				if (req_type_t'(req.req_type) == REQ_TICK) begin
					clock_q <= clock_q + CLOCK_W'(req.elapsed_ms);
				end
			end
			if (send_go && send_ok) begin
				busy_q[free_idx] <= 1'b1;
				bif_q            <= bif_q + BIF_W'(len_q);
				next_seq_q       <= next_seq_q + SEQ_W'(len_q);
			end
			if (advance) begin
				valid_s1 <= issue;
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (!is_tick_q && ack_free) begin
					busy_q[idx_s1] <= 1'b0;
					freed_q        <= freed_q + CNT_W'(1);
					bif_q          <= bif_q - BIF_W'(rd_len);
				end
				if (is_tick_q && due) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (state_q == S_TICK_DONE && push) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ack_q <= req.ack_number;
			len_q <= len_sat;
		end
		if (issue) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (advance && is_tick_q && due) begin
			pend_seq_q <= rd_seq;
			pend_len_q <= rd_len;
			pend_idx_q <= idx_s1;
		end
	end

	arqswt_slot_ram #(
		.DEPTH  (SLOTS),
		.IDX_W  (IDX_W),
		.DATA_W (ENT_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	arqswt_out_reg #(
		.LEN_W (LEN_W),
		.IDX_W (IDX_W),
		.BIF_W (BIF_W),
		.CNT_W (CNT_W)
	) u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.kind   (o_kind),
		.status (o_status),
		.seq    (o_seq),
		.len    (o_len),
		.slot   (o_slot),
		.bif    (o_bif),
		.freed  (o_freed),
		.last   (o_last),
		.free   (out_free),
		.res    (res)
	);
endmodule
`default_nettype wire
